/* src/vpac_pkg.sv */
// ----------------------------------------------------------------------------
// vpac_pkg
// Shared types and constants for the printable-ASCII Vigenere cipher.
// ----------------------------------------------------------------------------
package vpac_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned KEY_ENTRY_W  = 7;
	localparam int unsigned KEY_WORD_N   = 8;
	localparam int unsigned KEY_LEN_W    = 5;
	localparam int unsigned KEY_POS_W    = 4;
	localparam int unsigned CFG_DATA_W   = KEY_ENTRY_W * KEY_WORD_N;
	localparam int unsigned CFG_INDEX_W  = 2;

	localparam int unsigned MAX_KEY_ENTRIES = 16;

	localparam logic [BYTE_W-1:0]      PRINT_LOW  = 8'd32;
	localparam logic [BYTE_W-1:0]      PRINT_HIGH = 8'd126;
	localparam logic [KEY_ENTRY_W-1:0] PRINT_SPAN = 7'd95;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DECRYPT_MODE = 2'd0,
		CFG_KEY_LENGTH   = 2'd1,
		CFG_KEY_LOW      = 2'd2,
		CFG_KEY_HIGH     = 2'd3
	} cfg_index_t;

	typedef logic [KEY_WORD_N-1:0][KEY_ENTRY_W-1:0] key_word_t;

	// One byte on its way to the shift unit: shift already reduced to 0..94.
	typedef struct packed {
		logic                   decrypt;
		logic [KEY_ENTRY_W-1:0] shift;
		logic [BYTE_W-1:0]      data;
	} shift_req_t;

endpackage

/* src/vigenere_printable_ascii_cipher.sv */
// ----------------------------------------------------------------------------
// vigenere_printable_ascii_cipher
// Printable-ASCII Vigenere stream cipher, one byte in and one byte out.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  data      data_valid / data_stall      data_byte, restart
//  result    result_valid / result_stall  result_byte
//  config    cfg_write_en                 cfg_index, cfg_data
//
//  Two register stages: the key entry is picked and reduced at the input
//  register, the modulo-95 add or subtract runs into the result register.
//  One byte per cycle sustained while the result channel is not stalled.
//  Each stage holds while the one after it is full and stalled.
//  Reset clears the key position, the stage valids and the registers to
//  encrypt, length 1, all-zero key.
// ----------------------------------------------------------------------------
module vigenere_printable_ascii_cipher
	import vpac_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   data_valid,
	output logic                   data_stall,
	input  logic [BYTE_W-1:0]      data_byte,
	input  logic                   restart,

	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [BYTE_W-1:0]      result_byte
);

	logic                 decrypt_mode_q;
	logic [KEY_LEN_W-1:0] key_length_q;
	key_word_t            key_low_q;
	key_word_t            key_high_q;
	logic [KEY_POS_W-1:0] key_pos_q;

	logic                 valid_s1;
	shift_req_t           req_s1;
	logic                 valid_s2;
	logic [BYTE_W-1:0]    result_s2;

	logic                   adv_s1;
	logic                   adv_s2;
	logic                   accept;
	logic [KEY_POS_W-1:0]   pos;
	logic [KEY_LEN_W-1:0]   len_eff;
	logic [KEY_LEN_W-1:0]   pos_next;
	logic [KEY_ENTRY_W-1:0] entry;
	shift_req_t             req_in;
	logic [BYTE_W-1:0]      shift_result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_mode_q <= 1'b0;
			key_length_q   <= KEY_LEN_W'(1);
			key_low_q      <= '0;
			key_high_q     <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DECRYPT_MODE: decrypt_mode_q <= cfg_data[0];
				CFG_KEY_LENGTH:   key_length_q   <= cfg_data[KEY_LEN_W-1:0];
				CFG_KEY_LOW:      key_low_q      <= cfg_data;
				CFG_KEY_HIGH:     key_high_q     <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Handshake: each stage moves when the stage after it can take its item
	assign adv_s2     = !valid_s2 || !result_stall;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign data_stall = !adv_s1;
	assign accept     = data_valid && adv_s1;

	always_comb begin
		pos = restart ? '0 : key_pos_q;

		if (key_length_q == '0) begin
			len_eff = KEY_LEN_W'(1);
		end else if (key_length_q > KEY_LEN_W'(MAX_KEY_ENTRIES)) begin
			len_eff = KEY_LEN_W'(MAX_KEY_ENTRIES);
		end else begin
			len_eff = key_length_q;
		end

		pos_next = {1'b0, pos} + KEY_LEN_W'(1);
		if (pos_next >= len_eff) begin
			pos_next = '0;
		end

		entry = pos[KEY_POS_W-1] ? key_high_q[pos[KEY_POS_W-2:0]]
		                         : key_low_q[pos[KEY_POS_W-2:0]];

		req_in.decrypt = decrypt_mode_q;
		req_in.data    = data_byte;
		// entries 95..127 fold back once
		if (entry >= PRINT_SPAN) begin
			req_in.shift = entry - PRINT_SPAN;
		end else begin
			req_in.shift = entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (accept) begin
				key_pos_q <= pos_next[KEY_POS_W-1:0];
			end
			if (adv_s1) begin
				valid_s1 <= data_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
		end
		if (adv_s2 && valid_s1) begin
			result_s2 <= shift_result;
		end
	end

	vpac_shift u_shift (
		.req    (req_s1),
		.result (shift_result)
	);

	assign result_valid = valid_s2;
	assign result_byte  = result_s2;

endmodule

/* src/vpac_shift.sv */
// ----------------------------------------------------------------------------
// vpac_shift
// Modulo-95 shift of one printable byte; other bytes pass unchanged.
// ----------------------------------------------------------------------------
module vpac_shift
	import vpac_pkg::*;
(
	input  shift_req_t        req,
	output logic [BYTE_W-1:0] result
);

	logic                   printable;
	logic [KEY_ENTRY_W-1:0] v;
	logic [KEY_ENTRY_W:0]   sum;
	logic [KEY_ENTRY_W:0]   diff;
	logic [KEY_ENTRY_W-1:0] v_new;
	logic [BYTE_W-1:0]      offset;

	always_comb begin
		printable = (req.data >= PRINT_LOW) && (req.data <= PRINT_HIGH);
		offset    = req.data - PRINT_LOW;
		v         = offset[KEY_ENTRY_W-1:0];
		sum       = {1'b0, v} + {1'b0, req.shift};
		diff      = {1'b0, v} - {1'b0, req.shift};
		if (req.decrypt) begin
			// borrow out means the difference went negative: wrap up by the span
			if (diff[KEY_ENTRY_W]) begin
				v_new = diff[KEY_ENTRY_W-1:0] + PRINT_SPAN;
			end else begin
				v_new = diff[KEY_ENTRY_W-1:0];
			end
		end else begin
			if (sum >= {1'b0, PRINT_SPAN}) begin
				v_new = KEY_ENTRY_W'(sum - {1'b0, PRINT_SPAN});
			end else begin
				v_new = sum[KEY_ENTRY_W-1:0];
			end
		end
		if (printable) begin
			result = {1'b0, v_new} + PRINT_LOW;
		end else begin
			result = req.data;
		end
	end

endmodule

/* dv/vigenere_printable_ascii_cipher_tb.sv */
// ----------------------------------------------------------------------------
// vigenere_printable_ascii_cipher_tb
// Self-checking bench for the printable-ASCII Vigenere stream cipher. A
// scoreboard keeps its own copy of the key registers and key position and
// predicts each result byte when a request is accepted. Results are matched
// in order. A directed part covers the printable edges, key entries of 95 and
// above, and out-of-range and shortened key lengths. Random phases follow,
// each with fresh settings and random idling on both channels.
// ----------------------------------------------------------------------------
module vigenere_printable_ascii_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vpac_pkg::*;

	class vigenere_scoreboard;
		logic                   decrypt;
		logic [KEY_LEN_W-1:0]   key_len;
		key_word_t              key_lo;
		key_word_t              key_hi;
		logic [KEY_POS_W-1:0]   key_pos;
		logic [BYTE_W-1:0]      expected_bytes[$];
		int unsigned            mismatches;

		function new();
			decrypt     = 1'b0;
			key_len     = 5'd1;
			key_lo      = '0;
			key_hi      = '0;
			key_pos     = '0;
			mismatches  = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_DECRYPT_MODE: decrypt = value[0];
				CFG_KEY_LENGTH:   key_len = value[KEY_LEN_W-1:0];
				CFG_KEY_LOW:      key_lo  = value;
				CFG_KEY_HIGH:     key_hi  = value;
				default: ;
			endcase
		endfunction

		function void note_request(logic [BYTE_W-1:0] data, logic restart_pos);
			int unsigned       len;
			int unsigned       entry;
			int unsigned       shift;
			int unsigned       v;
			int unsigned       nxt;
			logic [BYTE_W-1:0] res;
			len = (key_len == 0) ? 1 :
				(key_len > MAX_KEY_ENTRIES) ? MAX_KEY_ENTRIES : 32'(key_len);
			if (restart_pos)
				key_pos = '0;
			entry = 32'(key_pos[3] ? key_hi[key_pos[2:0]] : key_lo[key_pos[2:0]]);
			shift = entry % 32'(PRINT_SPAN);
			res = data;
			if (data >= PRINT_LOW && data <= PRINT_HIGH) begin
				v = 32'(data) - 32'(PRINT_LOW);
				if (decrypt)
					v = (v + 32'(PRINT_SPAN) - shift) % 32'(PRINT_SPAN);
				else
					v = (v + shift) % 32'(PRINT_SPAN);
				res = BYTE_W'(v + 32'(PRINT_LOW));
			end
			// a shortened length wraps as soon as position + 1 is not below it
			nxt = 32'(key_pos) + 1;
			key_pos = (nxt >= len) ? '0 : nxt[KEY_POS_W-1:0];
			expected_bytes = {expected_bytes, res};
		endfunction

		function void check_result(logic [BYTE_W-1:0] got);
			logic [BYTE_W-1:0] want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches < 100)
					$display("%0t: result_byte expected none got %02h", $time, got);
			end else begin
				want = expected_bytes.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches < 100)
						$display("%0t: result_byte expected %02h got %02h", $time, want, got);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   data_valid   = 1'b0;
	logic                   data_stall;
	logic [BYTE_W-1:0]      data_byte    = '0;
	logic                   restart      = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b1;
	logic [BYTE_W-1:0]      result_byte;

	vigenere_scoreboard     sb = new();
	bit                     no_idle = 1'b0;

	vigenere_printable_ascii_cipher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_byte  (result_byte)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned draw_wait();
		if (no_idle)
			return 0;
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 18);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[CFG_DATA_W-1:0];
	endfunction

	// Write all four registers back to back; junk rides in the unused upper bits.
	task automatic program_cipher(logic mode, logic [KEY_LEN_W-1:0] len,
			key_word_t lo, key_word_t hi);
		logic [CFG_DATA_W-1:0] value;
		cfg_index_t            idx;
		for (int i = 0; i < 4; i++) begin
			idx = cfg_index_t'(i);
			value = rand_word();
			case (idx)
				CFG_DECRYPT_MODE: value[0] = mode;
				CFG_KEY_LENGTH:   value[KEY_LEN_W-1:0] = len;
				CFG_KEY_LOW:      value = lo;
				CFG_KEY_HIGH:     value = hi;
				default: ;
			endcase
			cfg_write_en <= 1'b1;
			cfg_index    <= idx;
			cfg_data     <= value;
			@(posedge clk);
			sb.write_reg(idx, value);
		end
		cfg_write_en <= 1'b0;
	endtask

	// Leaves data_valid high on return so the next request can go back to back.
	task automatic send_request(logic [BYTE_W-1:0] data, logic restart_pos);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= data;
		restart    <= restart_pos;
		do @(posedge clk); while (data_stall);
		sb.note_request(data, restart_pos);
	endtask

	task automatic drain();
		data_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Receiver: hold off a random number of cycles, then take one result.
	initial begin
		int unsigned hold;
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		logic              fire;
		logic [BYTE_W-1:0] got;
		forever begin
			@(posedge clk);
			fire = result_valid && !result_stall && arst_n;
			got  = result_byte;
			// let the request side note this edge first
			#1;
			if (fire)
				sb.check_result(got);
		end
	end

	initial begin
		#10ms;
		$display("vigenere_printable_ascii_cipher_tb: FAIL");
		$finish;
	end

	initial begin
		key_word_t             lo;
		key_word_t             hi;
		logic [KEY_LEN_W-1:0]  len;
		int unsigned           sent;
		int unsigned           count;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encrypt, length 4: key entries of 0, 94, 95 and 127 across the byte edges.
		lo = rand_word();
		hi = rand_word();
		lo[0] = 7'd0;
		lo[1] = 7'd94;
		lo[2] = 7'd95;
		lo[3] = 7'd127;
		program_cipher(1'b0, 5'd4, lo, hi);
		send_request(8'h00, 1'b1);
		send_request(8'd31, 1'b0);
		send_request(8'd32, 1'b0);
		send_request(8'd126, 1'b0);
		send_request(8'd127, 1'b1);
		send_request(8'hff, 1'b0);
		send_request("a", 1'b0);
		send_request("~", 1'b0);
		drain();

		// Decrypt with length zero: acts as length 1, entry 0 only.
		lo[0] = 7'd127;
		program_cipher(1'b1, 5'd0, lo, hi);
		send_request(" ", 1'b0);
		send_request("~", 1'b0);
		send_request(8'h80, 1'b0);
		send_request("a", 1'b0);
		drain();

		// Length 31 clamps to 16; walk the position up to entry 12.
		program_cipher(1'b0, 5'd31, rand_word(), rand_word());
		for (int i = 0; i < 12; i++)
			send_request(8'($urandom_range(32, 126)), i == 0);
		drain();

		// Shorten below the position: entry 12 once, then wrap to 0.
		program_cipher(1'b1, 5'd3, sb.key_lo, sb.key_hi);
		for (int i = 0; i < 3; i++)
			send_request(8'($urandom_range(32, 126)), 1'b0);
		drain();

		sent = 0;
		while (sent < 1450) begin
			case ($urandom_range(0, 9))
				0:       len = 5'd0;
				1:       len = 5'($urandom_range(17, 31));
				2:       len = 5'd16;
				default: len = 5'($urandom_range(1, 16));
			endcase
			program_cipher(1'($urandom), len, rand_word(), rand_word());
			no_idle = ($urandom_range(0, 3) == 0);
			count = $urandom_range(20, 120);
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 9) < 7)
					send_request(8'($urandom_range(32, 126)),
						$urandom_range(0, 9) == 0);
				else
					send_request(8'($urandom_range(0, 255)),
						$urandom_range(0, 9) == 0);
			end
			sent += count;
			drain();
			no_idle = 1'b0;
		end

		if (sb.mismatches == 0)
			$display("vigenere_printable_ascii_cipher_tb: PASS");
		else
			$display("vigenere_printable_ascii_cipher_tb: FAIL");
		$finish;
	end

endmodule
